// ===== rtl/core/b2x2_pkg.sv =====
`default_nettype none

package b2x2_pkg;

  // Size of the design.
  localparam int MAX_WIDTH  = 4096;
  localparam int PIXEL_BITS = 12;

  // Derived widths.
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 14;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PAIR_W     = PIXEL_BITS + 1;
  localparam int QUAD_W     = PIXEL_BITS + 2;

  // Widths of the fixed port fields.
  localparam int PIX_PORT_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 14;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Reset values of the geometry, stored as last column and last row.
  localparam logic [COL_W-1:0] RESET_COL_LAST = COL_W'(639);
  localparam logic [ROW_W-1:0] RESET_ROW_LAST = ROW_W'(479);

  // What the position stage hands to the output stage for one word.
  typedef struct packed {
    logic [PAIR_W-1:0] pair_sum;
    logic              odd_row;
    logic              odd_col;
    logic              last_col;
    logic              last_row;
    logic              emit;
  } pos_info_t;

endpackage

`default_nettype wire

// ===== rtl/core/b2x2_pix_if.sv =====
`default_nettype none

interface b2x2_pix_if;
  import b2x2_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b2x2_res_if.sv =====
`default_nettype none

interface b2x2_res_if;
  import b2x2_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PIX_PORT_W-1:0] out_pixel;
  logic                  row_end;
  logic                  frame_end;

  modport source (output valid, output out_pixel, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input out_pixel, input row_end, input frame_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b2x2_cfg_if.sv =====
`default_nettype none

interface b2x2_cfg_if;
  import b2x2_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b2x2_pos.sv =====
`default_nettype none

module b2x2_pos
  import b2x2_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  b2x2_cfg_if.sink                cfg,
  input  wire logic               fire,
  input  wire logic [PIX_PORT_W-1:0] pixel,
  output pos_info_t               info,
  output logic                    wr_en,
  output logic                    rd_en,
  output logic [SLOT_W-1:0]       slot,
  output logic [PAIR_W-1:0]       wr_data
);

  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_last;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [PAIR_W-1:0] pair_sum;
  logic [PAIR_W-1:0] pair_sum_next;
  logic [PIXEL_BITS-1:0] px;
  logic              odd_col;
  logic              odd_row;
  logic              last_col;
  logic              last_row;
  logic [WIDTH_REG_W-1:0]  width_in;
  logic [HEIGHT_REG_W-1:0] height_in;

  assign cfg.ready = 1'b1;
  assign width_in  = cfg.data[WIDTH_REG_W-1:0];
  assign height_in = cfg.data[HEIGHT_REG_W-1:0];

  // Position of the current word in the frame.
  assign px       = pixel[PIXEL_BITS-1:0];
  assign odd_col  = column_count[0];
  assign odd_row  = row_count[0];
  assign last_col = (column_count == col_last);
  assign last_row = (row_count == row_last);

  // Horizontal pair sum: restart on even columns, accumulate on odd ones.
  assign pair_sum_next = odd_col ? (pair_sum + PAIR_W'(px)) : PAIR_W'(px);

  // Even rows store pair sums; odd rows read them back.
  assign slot    = column_count[COL_W-1:1];
  assign wr_data = pair_sum_next;
  assign wr_en   = fire && !odd_row && (odd_col || last_col);
  assign rd_en   = fire && odd_row;

  always_comb begin
    info.pair_sum = pair_sum_next;
    info.odd_row  = odd_row;
    info.odd_col  = odd_col;
    info.last_col = last_col;
    info.last_row = last_row;
    info.emit     = (odd_col || last_col) && (odd_row || last_row);
  end

  // Geometry registers, frame counters and the running pair sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_last     <= RESET_COL_LAST;
      row_last     <= RESET_ROW_LAST;
      column_count <= '0;
      row_count    <= '0;
      pair_sum     <= '0;
    end else if (cfg.valid) begin
      // A width or height write restarts the frame; zero acts as one, width saturates.
      if (cfg.index == REG_IMAGE_WIDTH) begin
        column_count <= '0;
        row_count    <= '0;
        if (width_in == '0) begin
          col_last <= '0;
        end else if (32'(width_in) > MAX_WIDTH) begin
          col_last <= COL_W'(MAX_WIDTH - 1);
        end else begin
          col_last <= COL_W'(width_in - WIDTH_REG_W'(1));
        end
      end else if (cfg.index == REG_IMAGE_HEIGHT) begin
        column_count <= '0;
        row_count    <= '0;
        if (height_in == '0) begin
          row_last <= '0;
        end else begin
          row_last <= ROW_W'(height_in - HEIGHT_REG_W'(1));
        end
      end
    end else if (fire) begin
      pair_sum <= pair_sum_next;
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b2x2_linebuf.sv =====
`default_nettype none

module b2x2_linebuf
  import b2x2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              rd_en,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [PAIR_W-1:0] wr_data,
  output logic      [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem [LINE_DEPTH];

  // One pair sum per column pair; read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[slot];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/b2x2_out.sv =====
`default_nettype none

module b2x2_out
  import b2x2_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  pos_info_t              info,
  input  wire logic [PAIR_W-1:0] rd_data,
  output logic                   in_ready,
  b2x2_res_if.source             res
);

  pos_info_t         s1;
  logic              s1_valid;
  logic              s1_go;
  logic              out_free;
  logic [QUAD_W-1:0] sum;
  logic [QUAD_W-1:0] avg;

  // A word with no result leaves the stage without waiting for the output.
  assign out_free = !res.valid || res.ready;
  assign s1_go    = s1_valid && (!s1.emit || out_free);
  assign in_ready = !s1_valid || s1_go;

  // Average of the stored row pair with this row, or of this row alone.
  always_comb begin
    sum = QUAD_W'(rd_data) + QUAD_W'(s1.pair_sum);
    if (s1.odd_row) begin
      avg = s1.odd_col ? (sum >> 2) : (sum >> 1);
    end else begin
      avg = s1.odd_col ? QUAD_W'(s1.pair_sum >> 1) : QUAD_W'(s1.pair_sum);
    end
  end

  // Stage register after the line buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
    if (fire) begin
      s1 <= info;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_go && s1.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (s1_go && s1.emit) begin
      res.out_pixel <= PIX_PORT_W'(avg[PIXEL_BITS-1:0]);
      res.row_end   <= s1.last_col;
      res.frame_end <= s1.last_col && s1.last_row;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/binning_2x2_downsampler_unit.sv =====
// Channel   Modport  Word
// pix_in    sink     pixel (12 bits), raster order
// res_out   source   out_pixel (12 bits), row_end, frame_end
// cfg       sink     index 0 image_width, index 1 image_height
//
// One pixel is taken every cycle unless a stalled result stops intake.
// The pair-sum line buffer is read and written at the accept edge; its read register
// and the result register form the two stages.
// Reset sets 640 x 480 and starts a frame; the line buffer is not cleared.
// A stalled result stops intake only once the stage behind it holds a producing word.
`default_nettype none

module binning_2x2_downsampler_unit
  import b2x2_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  b2x2_pix_if.sink    pix_in,
  b2x2_res_if.source  res_out,
  b2x2_cfg_if.sink    cfg
);

  pos_info_t         info;
  logic              fire;
  logic              in_ready;
  logic              wr_en;
  logic              rd_en;
  logic [SLOT_W-1:0] slot;
  logic [PAIR_W-1:0] wr_data;
  logic [PAIR_W-1:0] rd_data;

  assign pix_in.ready = in_ready;
  assign fire         = pix_in.valid && in_ready;

  b2x2_pos u_pos (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .pixel   (pix_in.pixel),
    .info    (info),
    .wr_en   (wr_en),
    .rd_en   (rd_en),
    .slot    (slot),
    .wr_data (wr_data)
  );

  b2x2_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .rd_en   (rd_en),
    .slot    (slot),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  b2x2_out u_out (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .info     (info),
    .rd_data  (rd_data),
    .in_ready (in_ready),
    .res      (res_out)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import b2x2_pkg::*;

  // One binned output word as it leaves the block.
  typedef struct packed {
    logic [PIX_PORT_W-1:0] out_pixel;
    logic                  row_end;
    logic                  frame_end;
  } binned_word_t;

  // Rows of the directed stimulus table.
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_PORT_W-1:0] pixel;
    logic                  typed;
    logic                  typed_emit;
    binned_word_t          typed_word;
  } bench_row_t;

  // How often each side of the stream idles.
  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  // Indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_PIXELS = 680;
  localparam int EDGE_PIXELS   = 64;

  logic clk;
  logic rst;

  b2x2_pix_if pix_ch ();
  b2x2_res_if res_ch ();
  b2x2_cfg_if cfg_ch ();

  binning_2x2_downsampler_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_ch),
    .res_out (res_ch),
    .cfg     (cfg_ch)
  );

  // Predictor state: geometry, raster position and pair sums.
  logic [WIDTH_REG_W-1:0]  geo_width;
  logic [HEIGHT_REG_W-1:0] geo_height;
  int                      col_pos;
  int                      row_pos;
  logic [PAIR_W-1:0]       run_pair;
  logic [PAIR_W-1:0]       pair_line [LINE_DEPTH];

  binned_word_t pending_bins [$];
  bench_row_t   bench_rows [$];
  int           mismatches;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int eff_width();
    int w;
    w = (geo_width == '0) ? 1 : int'(geo_width);
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    return (geo_height == '0) ? 1 : int'(geo_height);
  endfunction

  // A register write restarts the frame; the spare indexes change nothing.
  function automatic void apply_geometry(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      geo_width = data[WIDTH_REG_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      geo_height = data[HEIGHT_REG_W-1:0];
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  // Works out the binned word, if any, that one accepted pixel produces.
  task automatic bin_pixel(input logic [PIX_PORT_W-1:0] px, output bit emit,
                           output binned_word_t word);
    int w, h, col, row, slot, value;
    bit last_col, last_row;
    w = eff_width();
    h = eff_height();
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;
    slot = (col / 2) % LINE_DEPTH;
    last_col = (col == w - 1);
    last_row = (row == h - 1);
    emit = 1'b0;
    value = 0;

    // Even rows build pair sums; odd rows and an odd last row emit.
    if (row % 2 == 0) begin
      if (col % 2 == 0) begin
        run_pair = PAIR_W'(px);
        if (last_col) begin
          pair_line[slot] = PAIR_W'(px);
          if (last_row) begin
            emit = 1'b1;
            value = int'(px);
          end
        end
      end else begin
        run_pair = run_pair + PAIR_W'(px);
        pair_line[slot] = run_pair;
        if (last_row) begin
          emit = 1'b1;
          value = int'(run_pair) >> 1;
        end
      end
    end else begin
      if (col % 2 == 0) begin
        run_pair = PAIR_W'(px);
        if (last_col) begin
          emit = 1'b1;
          value = (int'(pair_line[slot]) + int'(px)) >> 1;
        end
      end else begin
        emit = 1'b1;
        value = (int'(pair_line[slot]) + int'(run_pair) + int'(px)) >> 2;
      end
    end

    word.out_pixel = value[PIX_PORT_W-1:0];
    word.row_end   = last_col;
    word.frame_end = last_col && last_row;

    col_pos = col + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic void set_pace(pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_idle_pct = 82;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_idle_pct = 0;
        recv_stall_pct = 82;
      end
      default: begin
        send_idle_pct = 13;
        recv_stall_pct = 13;
      end
    endcase
  endfunction

  function automatic logic [PIX_PORT_W-1:0] rand_pixel();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return PIX_PORT_W'($urandom);
    endcase
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    bench_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.index = idx;
    r.data = data;
    bench_rows.push_back(r);
  endfunction

  function automatic void add_pix(logic [PIX_PORT_W-1:0] px);
    bench_row_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.pixel = px;
    bench_rows.push_back(r);
  endfunction

  function automatic void add_pix_typed(logic [PIX_PORT_W-1:0] px, bit emit,
                                        logic [PIX_PORT_W-1:0] out_px, bit re, bit fe);
    bench_row_t r;
    r = '0;
    r.kind = ROW_PIX;
    r.pixel = px;
    r.typed = 1'b1;
    r.typed_emit = emit;
    r.typed_word = '{out_pixel: out_px, row_end: re, frame_end: fe};
    bench_rows.push_back(r);
  endfunction

  // Offers one pixel word, waits for it to be taken and records what it should produce.
  task automatic send_pixel(input logic [PIX_PORT_W-1:0] px, input bit typed,
                            input bit typed_emit, input binned_word_t typed_word);
    int gap;
    bit emit;
    binned_word_t word;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (!pix_ch.ready);
    bin_pixel(px, emit, word);
    if (typed) begin
      emit = typed_emit;
      word = typed_word;
    end
    if (emit) pending_bins.push_back(word);
  endtask

  // Register writes go in only once the block has drained and settled.
  task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    pix_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_geometry(idx, data);
  endtask

  task automatic send_frames(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel(), 1'b0, 1'b0, '0);
  endtask

  // The receiver stalls at random according to the current pace.
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Each result word is checked against the oldest expected word.
  always @(posedge clk) begin
    binned_word_t exp_word;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_bins.size() == 0) begin
        $error("unexpected word: out_pixel %0d row_end %0b frame_end %0b",
               res_ch.out_pixel, res_ch.row_end, res_ch.frame_end);
        mismatches++;
      end else begin
        exp_word = pending_bins.pop_front();
        if (res_ch.out_pixel !== exp_word.out_pixel) begin
          $error("out_pixel: expected %0d, got %0d", exp_word.out_pixel, res_ch.out_pixel);
          mismatches++;
        end
        if (res_ch.row_end !== exp_word.row_end) begin
          $error("row_end: expected %0b, got %0b", exp_word.row_end, res_ch.row_end);
          mismatches++;
        end
        if (res_ch.frame_end !== exp_word.frame_end) begin
          $error("frame_end: expected %0b, got %0b", exp_word.frame_end, res_ch.frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long without any word moving on any channel ends the run.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("binning_2x2_downsampler_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int random_items;
    int frame_px;
    int n_px;
    int w_sel;
    int h_sel;

    clk = 1'b0;
    rst = 1'b1;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_IMAGE_WIDTH;
    cfg_ch.data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    geo_width = WIDTH_REG_W'(640);
    geo_height = HEIGHT_REG_W'(480);
    col_pos = 0;
    row_pos = 0;
    run_pair = '0;
    set_pace(PACE_FULL);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The reset geometry of 640 x 480 yields nothing for the first pair.
    add_pix_typed(12'hABC, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'h543, 1'b0, '0, 1'b0, 1'b0);
    // Zero width and height act as one: every pixel is a corner passed through.
    add_cfg(REG_IMAGE_WIDTH, '0);
    add_cfg(REG_IMAGE_HEIGHT, '0);
    add_pix_typed(12'hFFF, 1'b1, 12'hFFF, 1'b1, 1'b1);
    add_pix_typed(12'h000, 1'b1, 12'h000, 1'b1, 1'b1);
    // A full-scale 2x2 block, then a block that truncates to zero.
    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
    add_pix_typed(12'hFFF, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'hFFF, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'hFFF, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'hFFF, 1'b1, 12'hFFF, 1'b1, 1'b1);
    add_pix_typed(12'h000, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'h000, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'h000, 1'b0, '0, 1'b0, 1'b0);
    add_pix_typed(12'h001, 1'b1, 12'h000, 1'b1, 1'b1);
    // A 3 x 3 frame covers the odd last column, odd last row and odd corner.
    // Writes to indexes without a register fall mid-frame and must not restart it.
    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    add_pix(12'h801);
    add_pix(12'h7FF);
    add_pix(12'hFFF);
    add_cfg(REG_SPARE_A, 14'h3FFF);
    add_pix(12'h000);
    add_pix(12'h555);
    add_cfg(REG_SPARE_B, '0);
    add_pix(12'hAAA);
    add_pix(12'h123);
    add_pix(12'hFED);
    add_pix(12'h3C3);

    foreach (bench_rows[i]) begin
      if (bench_rows[i].kind == ROW_CFG) begin
        write_geometry(bench_rows[i].index, bench_rows[i].data);
      end else begin
        send_pixel(bench_rows[i].pixel, bench_rows[i].typed, bench_rows[i].typed_emit,
                   bench_rows[i].typed_word);
      end
    end

    // Random part: small frames, mostly whole, some cut short by a new geometry.
    phase = 0;
    random_items = 0;
    while (random_items < RANDOM_PIXELS) begin
      phase++;
      set_pace(pace_t'(phase % 4));
      case ($urandom_range(0, 7))
        0: w_sel = 0;
        1: w_sel = $urandom_range(10, 80);
        default: w_sel = $urandom_range(1, 9);
      endcase
      if (w_sel > 9) h_sel = $urandom_range(1, 4);
      else if ($urandom_range(0, 7) == 0) h_sel = 0;
      else h_sel = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) write_geometry(REG_IMAGE_WIDTH, CFG_DATA_W'(w_sel));
      if ($urandom_range(0, 3) != 0) write_geometry(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_sel));
      if ($urandom_range(0, 7) == 0) begin
        write_geometry($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                       CFG_DATA_W'($urandom));
      end
      frame_px = eff_width() * eff_height();
      n_px = frame_px * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) n_px += $urandom_range(0, frame_px - 1);
      send_frames(n_px);
      random_items += n_px;
    end

    // Start of the widest frames: a width above the maximum acts as the maximum.
    set_pace(PACE_FULL);
    write_geometry(REG_IMAGE_WIDTH, 14'h3FFF);
    write_geometry(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    send_frames(EDGE_PIXELS);
    set_pace(PACE_BOTH);
    write_geometry(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH));
    write_geometry(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    send_frames(EDGE_PIXELS);

    // Start of the tallest frame, one column wide.
    set_pace(PACE_RECV_STALLS);
    write_geometry(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
    write_geometry(REG_IMAGE_HEIGHT, 14'h3FFF);
    send_frames(EDGE_PIXELS);

    // Drain and let any stray word show up.
    pix_ch.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("binning_2x2_downsampler_unit: match");
    end else begin
      $display("binning_2x2_downsampler_unit: mismatch");
    end
    $finish;
  end

endmodule
